[rtl/core/bal_pkg.sv]
// Shared types and constants for the bounded array list.
package bal_pkg;

	localparam logic [2:0] KIND_APPEND = 3'd0;
	localparam logic [2:0] KIND_INSERT = 3'd1;
	localparam logic [2:0] KIND_REMOVE = 3'd2;
	localparam logic [2:0] KIND_GET    = 3'd3;
	localparam logic [2:0] KIND_SEARCH = 3'd4;
	localparam logic [2:0] KIND_SWAP   = 3'd5;
	localparam logic [2:0] KIND_CLEAR  = 3'd6;

	localparam logic [31:0] WORD_INVALID   = 32'hFFFF_FFFF;
	localparam logic [4:0]  CAPACITY_RESET = 5'd10;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_SHIFT_UP,
		CELL_SHIFT_DOWN,
		CELL_ROTATE,
		CELL_CLEAR
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t  mode;
		logic [31:0] word;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWAP
	} state_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] read_data;
		logic        found;
		logic [3:0]  position;
		logic [4:0]  length;
	} result_t;

endpackage

[rtl/core/bounded_array_list.sv]
// Top level of the bounded array list: sequencer plus a row of entry cells.
//
//   port group    direction  handshake            payload
//   input item    in         in_valid / in_stall  kind, index, second_index, value
//   result item   out        out_valid/out_stall  ok, read_data, found, position, length
//   capacity      in         capacity_we          capacity_wdata
//
// Append, insert, remove, clear, search of an empty list and every failing item complete
// in one step: the cell row shifts or writes all entries at once, and the result is registered.
// Get and search rotate the row once past cell zero, and the input stays busy until the
// result is ready; swap adds a write-back revolution that writes the two entries back crossed.
// Reset clears all cells and the count and sets the capacity to 10.
// One finished result waits behind the stalled output register; the input stalls meanwhile.
module bounded_array_list #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         kind,
	input  logic [3:0]         index,
	input  logic [3:0]         second_index,
	input  logic signed [31:0] value,
	input  logic               capacity_we,
	input  logic [4:0]         capacity_wdata,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic signed [31:0] read_data,
	output logic               found,
	output logic [3:0]         position,
	output logic [4:0]         length
);
	import bal_pkg::*;

	localparam int FW = $clog2(DEPTH + 1);
	localparam int XW = (FW > 5) ? FW : 5;

	cell_cmd_t     cmd;
	result_t       result;
	logic [XW-1:0] target;
	logic [31:0]   tail;
	logic [31:0]   cell_data [DEPTH];

	bal_seq #(
		.DEPTH(DEPTH),
		.XW   (XW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.index         (index),
		.second_index  (second_index),
		.value         (value),
		.capacity_we   (capacity_we),
		.capacity_wdata(capacity_wdata),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result        (result),
		.head          (cell_data[0]),
		.cmd           (cmd),
		.target        (target),
		.tail          (tail)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [31:0] left_w;
		logic [31:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = tail;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		bal_cell #(
			.TW (XW),
			.IDX(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.target(target),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i])
		);
	end

	assign ok        = result.ok;
	assign read_data = result.read_data;
	assign found     = result.found;
	assign position  = result.position;
	assign length    = result.length;

endmodule

[rtl/core/bal_cell.sv]
// One storage cell of the list row: holds one entry and trades it with its neighbors.
module bal_cell #(
	parameter int TW  = 5,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bal_pkg::cell_cmd_t cmd,
	input  logic [TW-1:0]      target,
	input  logic [31:0]        left,
	input  logic [31:0]        right,
	output logic [31:0]        data
);
	import bal_pkg::*;

	localparam logic [TW-1:0] MY_IDX = TW'(IDX);

	logic [31:0] data_q;
	logic        at_pos;
	logic        above_pos;

	assign at_pos    = (target == MY_IDX);
	assign above_pos = (MY_IDX > target);
	assign data      = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			unique case (cmd.mode)
				CELL_HOLD: begin
					data_q <= data_q;
				end
				CELL_WRITE: begin
					if (at_pos) data_q <= cmd.word;
				end
				CELL_SHIFT_UP: begin
					// Cells above the insert point take the entry from below.
					if (above_pos) data_q <= left;
					else if (at_pos) data_q <= cmd.word;
				end
				CELL_SHIFT_DOWN: begin
					if (at_pos || above_pos) data_q <= right;
				end
				CELL_ROTATE: begin
					data_q <= right;
				end
				CELL_CLEAR: begin
					data_q <= '0;
				end
				default: begin
					data_q <= data_q;
				end
			endcase
		end
	end

endmodule

[rtl/core/bal_seq.sv]
// Sequencer for the list: decodes items, drives the cell row, keeps the count and the result.
module bal_seq #(
	parameter int DEPTH = 16,
	parameter int XW    = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          kind,
	input  logic [3:0]          index,
	input  logic [3:0]          second_index,
	input  logic [31:0]         value,
	input  logic                capacity_we,
	input  logic [4:0]          capacity_wdata,
	output logic                out_valid,
	input  logic                out_stall,
	output bal_pkg::result_t    result,
	input  logic [31:0]         head,
	output bal_pkg::cell_cmd_t  cmd,
	output logic [XW-1:0]       target,
	output logic [31:0]         tail
);
	import bal_pkg::*;

	localparam int FW = $clog2(DEPTH + 1);
	localparam int KW = $clog2(DEPTH);
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
	localparam logic [KW-1:0] LAST_K  = KW'(DEPTH - 1);

	state_t        state_q, state_d;
	logic [4:0]    cap_q;
	logic [FW-1:0] fill_q, fill_d;
	logic [KW-1:0] cnt_q;
	logic [2:0]    op_q;
	logic [3:0]    ia_q, ib_q;
	logic [31:0]   word_q, a_q, b_q;
	logic          fnd_q;
	logic [3:0]    pos_q;
	result_t       res_q, res_nx, out_q;
	logic          res_pend_q, out_valid_q;

	logic          accept, done, start_scan, out_free;
	logic [XW-1:0] fill_x, cap_x, bnd, ia_x, ib_x, cnt_x;
	logic          full, at_a, at_b, last, hit, fnd_now;
	logic [3:0]    pos_now;
	logic [31:0]   a_now;

	assign in_stall = (state_q != ST_IDLE) || res_pend_q;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign fill_x = XW'(fill_q);
	assign cap_x  = XW'(cap_q);
	assign bnd    = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
	assign full   = (fill_x >= bnd);
	assign ia_x   = XW'(index);
	assign ib_x   = XW'(second_index);

	// Scan side: entry number cnt_q sits in cell zero during a revolution.
	assign cnt_x   = XW'(cnt_q);
	assign at_a    = (cnt_x == XW'(ia_q));
	assign at_b    = (cnt_x == XW'(ib_q));
	assign last    = (cnt_q == LAST_K);
	assign hit     = (cnt_x < fill_x) && (head == word_q);
	assign fnd_now = fnd_q || hit;
	assign pos_now = fnd_q ? pos_q : (hit ? 4'(cnt_q) : 4'd0);
	assign a_now   = at_a ? head : a_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && start_scan) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last) state_d = (op_q == KIND_SWAP) ? ST_SWAP : ST_IDLE;
			end
			ST_SWAP: begin
				if (last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.mode   = CELL_HOLD;
		cmd.word   = value;
		target     = '0;
		tail       = head;
		fill_d     = fill_q;
		done       = 1'b0;
		start_scan = 1'b0;
		res_nx     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_APPEND: begin
							done = 1'b1;
							if (!full) begin
								cmd.mode  = CELL_WRITE;
								target    = fill_x;
								fill_d    = fill_q + 1'b1;
								res_nx.ok = 1'b1;
							end
						end
						KIND_INSERT: begin
							done = 1'b1;
							if (!full && (ia_x <= fill_x)) begin
								cmd.mode  = CELL_SHIFT_UP;
								target    = ia_x;
								fill_d    = fill_q + 1'b1;
								res_nx.ok = 1'b1;
							end
						end
						KIND_REMOVE: begin
							done = 1'b1;
							if (ia_x < fill_x) begin
								// The top cell takes zero, which clears the freed slot.
								cmd.mode  = CELL_SHIFT_DOWN;
								target    = ia_x;
								tail      = '0;
								fill_d    = fill_q - 1'b1;
								res_nx.ok = 1'b1;
							end
						end
						KIND_GET: begin
							if (ia_x < fill_x) begin
								start_scan = 1'b1;
							end else begin
								done             = 1'b1;
								res_nx.read_data = WORD_INVALID;
							end
						end
						KIND_SEARCH: begin
							if (fill_q == '0) begin
								done      = 1'b1;
								res_nx.ok = 1'b1;
							end else begin
								start_scan = 1'b1;
							end
						end
						KIND_SWAP: begin
							if ((ia_x < fill_x) && (ib_x < fill_x)) start_scan = 1'b1;
							else done = 1'b1;
						end
						KIND_CLEAR: begin
							done      = 1'b1;
							cmd.mode  = CELL_CLEAR;
							fill_d    = '0;
							res_nx.ok = 1'b1;
						end
						default: begin
							done = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.mode = CELL_ROTATE;
				tail     = head;
				if (last && (op_q != KIND_SWAP)) begin
					done      = 1'b1;
					res_nx.ok = 1'b1;
					if (op_q == KIND_GET) begin
						res_nx.read_data = a_now;
					end else begin
						res_nx.found    = fnd_now;
						res_nx.position = pos_now;
					end
				end
			end
			ST_SWAP: begin
				// Second revolution writes the two captured entries back crossed.
				cmd.mode = CELL_ROTATE;
				tail     = at_a ? b_q : (at_b ? a_q : head);
				if (last) begin
					done      = 1'b1;
					res_nx.ok = 1'b1;
				end
			end
			default: begin
				cmd.mode = CELL_HOLD;
			end
		endcase
		res_nx.length = 5'(fill_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAPACITY_RESET;
			fill_q      <= '0;
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (capacity_we) cap_q <= capacity_wdata;
			if (res_pend_q && out_free) begin
				out_valid_q <= 1'b1;
				res_pend_q  <= 1'b0;
			end else if (done) begin
				if (out_free) out_valid_q <= 1'b1;
				else res_pend_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_pend_q && out_free) begin
			out_q <= res_q;
		end else if (done) begin
			if (out_free) out_q <= res_nx;
			else res_q <= res_nx;
		end
		if (accept) begin
			op_q   <= kind;
			ia_q   <= index;
			ib_q   <= second_index;
			word_q <= value;
			cnt_q  <= '0;
			fnd_q  <= 1'b0;
			pos_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			cnt_q <= last ? '0 : cnt_q + 1'b1;
			a_q   <= a_now;
			if (at_b) b_q <= head;
			fnd_q <= fnd_now;
			pos_q <= pos_now;
		end else if (state_q == ST_SWAP) begin
			cnt_q <= last ? '0 : cnt_q + 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the bounded array list: list predictor, random traffic, stalls.
`timescale 1ns / 1ps

module tb_top;
	import bal_pkg::*;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 3 * DEPTH;
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         kind;
	logic [3:0]         index;
	logic [3:0]         second_index;
	logic signed [31:0] value;
	logic               capacity_we;
	logic [4:0]         capacity_wdata;
	logic               out_valid;
	logic               out_stall;
	logic               ok;
	logic signed [31:0] read_data;
	logic               found;
	logic [3:0]         position;
	logic [4:0]         length;

	// Mirrors the list contents and count, and queues the reply of every accepted item.
	class list_scoreboard;
		logic [31:0] entries [DEPTH];
		int unsigned fill;
		logic [4:0]  capacity;
		result_t     list_replies [$];
		int unsigned errors;
		int unsigned checked;

		function new();
			foreach (entries[i]) entries[i] = '0;
			fill = 0;
			capacity = CAPACITY_RESET;
			errors = 0;
			checked = 0;
		endfunction

		function void apply_list_op(logic [2:0] op, logic [3:0] ia, logic [3:0] ib,
				logic [31:0] word);
			result_t     r;
			int unsigned lim;
			int          i;
			logic [31:0] t;
			bit          full;
			r = '0;
			// A capacity above the storage depth is clipped to the depth.
			lim = (capacity > DEPTH) ? DEPTH : capacity;
			full = (fill >= lim);
			case (op)
			KIND_APPEND: begin
				if (!full) begin
					entries[fill] = word;
					fill++;
					r.ok = 1'b1;
				end
			end
			KIND_INSERT: begin
				if (!full && ia <= fill) begin
					for (i = fill; i > ia; i--) entries[i] = entries[i - 1];
					entries[ia] = word;
					fill++;
					r.ok = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (ia < fill) begin
					for (i = ia; i + 1 < fill; i++) entries[i] = entries[i + 1];
					entries[fill - 1] = '0;
					fill--;
					r.ok = 1'b1;
				end
			end
			KIND_GET: begin
				if (ia < fill) begin
					r.read_data = entries[ia];
					r.ok = 1'b1;
				end else begin
					r.read_data = WORD_INVALID;
				end
			end
			KIND_SEARCH: begin
				r.ok = 1'b1;
				for (i = 0; i < fill; i++) begin
					if (entries[i] == word) begin
						r.found = 1'b1;
						r.position = i[3:0];
						break;
					end
				end
			end
			KIND_SWAP: begin
				if (ia < fill && ib < fill) begin
					t = entries[ia];
					entries[ia] = entries[ib];
					entries[ib] = t;
					r.ok = 1'b1;
				end
			end
			KIND_CLEAR: begin
				foreach (entries[j]) entries[j] = '0;
				fill = 0;
				r.ok = 1'b1;
			end
			default: begin
			end
			endcase
			r.length = fill[4:0];
			list_replies.push_back(r);
		endfunction

		function void check_reply(result_t got);
			result_t want;
			if (list_replies.size() == 0) begin
				$error("result item arrived with no operation pending");
				errors++;
				return;
			end
			want = list_replies.pop_front();
			checked++;
			if (got.ok !== want.ok) begin
				$error("ok mismatch: expected %0d, actual %0d", want.ok, got.ok);
				errors++;
			end
			if (got.read_data !== want.read_data) begin
				$error("read_data mismatch: expected %0d, actual %0d",
					$signed(want.read_data), $signed(got.read_data));
				errors++;
			end
			if (got.found !== want.found) begin
				$error("found mismatch: expected %0d, actual %0d", want.found, got.found);
				errors++;
			end
			if (got.position !== want.position) begin
				$error("position mismatch: expected %0d, actual %0d",
					want.position, got.position);
				errors++;
			end
			if (got.length !== want.length) begin
				$error("length mismatch: expected %0d, actual %0d", want.length, got.length);
				errors++;
			end
		endfunction
	endclass

	list_scoreboard sb;
	int unsigned    cycle_count;
	int unsigned    burst_left;
	int unsigned    items_sent;
	int unsigned    settings_done;
	int unsigned    kind_count [8];
	int unsigned    hold_reqs;

	bounded_array_list #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.index          (index),
		.second_index   (second_index),
		.value          (value),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.ok             (ok),
		.read_data      (read_data),
		.found          (found),
		.position       (position),
		.length         (length)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Offers one item, opening a new burst after a random gap when the last one ran out.
	task automatic send_item(logic [2:0] op, logic [3:0] ia, logic [3:0] ib, logic [31:0] word);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= op;
		index <= ia;
		second_index <= ib;
		value <= word;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.apply_list_op(op, ia, ib, word);
		items_sent++;
		kind_count[op]++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.list_replies.size() != 0);
	endtask

	task automatic write_capacity(logic [4:0] cap);
		capacity_we <= 1'b1;
		capacity_wdata <= cap;
		@(posedge clk);
		capacity_we <= 1'b0;
		sb.capacity = cap;
		settings_done++;
	endtask

	// Mixes extremes, a few small words and live entries so that searches hit.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
		0: begin
			case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			default: return 32'h0;
			endcase
		end
		1: return 32'($urandom_range(0, 7));
		5: begin
			if (sb.fill > 0) return sb.entries[$urandom_range(0, sb.fill - 1)];
			return $urandom;
		end
		default: return $urandom;
		endcase
	endfunction

	// Mostly positions that the current count makes meaningful, sometimes any position.
	function automatic logic [3:0] pick_index();
		int unsigned top;
		top = (sb.fill > 15) ? 15 : sb.fill;
		if ($urandom_range(0, 3) != 0) return 4'($urandom_range(0, top));
		return 4'($urandom_range(0, 15));
	endfunction

	task automatic send_random(bit grow);
		int unsigned r;
		logic [2:0]  op;
		logic [31:0] word;
		r = $urandom_range(0, 99);
		if (grow) begin
			// Leans on append and insert, never clears, so the list reaches the depth.
			if (r < 35) op = KIND_APPEND;
			else if (r < 65) op = KIND_INSERT;
			else if (r < 75) op = KIND_REMOVE;
			else if (r < 85) op = KIND_GET;
			else if (r < 93) op = KIND_SEARCH;
			else if (r < 99) op = KIND_SWAP;
			else op = KIND_UNUSED;
		end else begin
			if (r < 22) op = KIND_APPEND;
			else if (r < 42) op = KIND_INSERT;
			else if (r < 58) op = KIND_REMOVE;
			else if (r < 70) op = KIND_GET;
			else if (r < 82) op = KIND_SEARCH;
			else if (r < 92) op = KIND_SWAP;
			else if (r < 95) op = KIND_CLEAR;
			else op = KIND_UNUSED;
		end
		if (op == KIND_SEARCH && sb.fill > 0 && $urandom_range(0, 9) < 6)
			word = sb.entries[$urandom_range(0, sb.fill - 1)];
		else
			word = pick_word();
		send_item(op, pick_index(), pick_index(), word);
	endtask

	// Receiver: stalls on a changing duty pattern, or holds off completely on request.
	initial begin
		int unsigned hold_left;
		int unsigned hold_seen;
		int unsigned pattern_left;
		int unsigned stall_pct;
		hold_left = 0;
		hold_seen = 0;
		pattern_left = 0;
		stall_pct = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_reply(result_t'{ok, read_data, found, position, length});
			if (hold_reqs != hold_seen) begin
				hold_left = HOLD_CYCLES;
				hold_seen = hold_reqs;
			end
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(16, 80);
				case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 30;
				default: stall_pct = 75;
				endcase
			end
			pattern_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin
		int p;
		sb = new();
		burst_left = 0;
		items_sent = 0;
		settings_done = 0;
		hold_reqs = 0;
		foreach (kind_count[k]) kind_count[k] = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_APPEND;
		index <= '0;
		second_index <= '0;
		value <= '0;
		capacity_we <= 1'b0;
		capacity_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at the reset capacity: empty list, extremes, each operation.
		send_item(KIND_GET, 4'd0, 4'd0, 32'h0);
		send_item(KIND_REMOVE, 4'd0, 4'd0, 32'h0);
		send_item(KIND_SWAP, 4'd0, 4'd0, 32'h0);
		send_item(KIND_SEARCH, 4'd0, 4'd0, 32'h0);
		send_item(KIND_APPEND, 4'd0, 4'd0, 32'h7FFF_FFFF);
		send_item(KIND_APPEND, 4'd15, 4'd15, 32'h8000_0000);
		send_item(KIND_INSERT, 4'd0, 4'd0, 32'hFFFF_FFFF);
		// Inserting at the count behaves as an append; an index past the count fails.
		send_item(KIND_INSERT, 4'd3, 4'd0, 32'h0);
		send_item(KIND_INSERT, 4'd6, 4'd0, 32'h1234_5678);
		send_item(KIND_GET, 4'd0, 4'd0, 32'h0);
		send_item(KIND_GET, 4'd15, 4'd0, 32'h0);
		send_item(KIND_SEARCH, 4'd0, 4'd0, 32'h8000_0000);
		send_item(KIND_SEARCH, 4'd0, 4'd0, 32'd12345);
		send_item(KIND_SWAP, 4'd0, 4'd3, 32'h0);
		send_item(KIND_SWAP, 4'd1, 4'd15, 32'h0);
		send_item(KIND_REMOVE, 4'd1, 4'd0, 32'h0);
		send_item(KIND_REMOVE, 4'd2, 4'd0, 32'h0);
		send_item(KIND_UNUSED, 4'd15, 4'd15, 32'hFFFF_FFFF);
		while (sb.fill < 10) send_item(KIND_APPEND, 4'd0, 4'd0, pick_word());
		send_item(KIND_APPEND, 4'd0, 4'd0, 32'd99);
		send_item(KIND_INSERT, 4'd0, 4'd0, 32'd98);
		send_item(KIND_CLEAR, 4'd0, 4'd0, 32'h0);

		// Full depth, with one long receiver hold-off while the sender keeps going.
		wait_drained();
		write_capacity(5'd16);
		repeat (8) send_item(KIND_APPEND, pick_index(), 4'd0, pick_word());
		hold_reqs++;
		repeat (60) send_random(1'b0);

		// Lower the capacity under the current count: the list must read as full.
		while (sb.fill < 8) send_item(KIND_APPEND, 4'd0, 4'd0, pick_word());
		wait_drained();
		write_capacity(5'd3);
		send_item(KIND_APPEND, 4'd0, 4'd0, 32'd7);
		send_item(KIND_INSERT, 4'd0, 4'd0, 32'd7);
		repeat (50) send_random(1'b0);

		wait_drained();
		write_capacity(5'd0);
		repeat (30) send_random(1'b0);

		wait_drained();
		write_capacity(5'd31);
		repeat (60) send_random(1'b1);

		wait_drained();
		write_capacity(5'd1);
		repeat (40) send_random(1'b0);

		for (p = 0; p < 3; p++) begin
			wait_drained();
			write_capacity(5'($urandom_range(0, 31)));
			repeat (40) send_random(p == 1);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d items under %0d capacity settings; %0d results checked.",
			items_sent, settings_done + 1, sb.checked);
		$display("By kind: append %0d, insert %0d, remove %0d, get %0d,",
			kind_count[0], kind_count[1], kind_count[2], kind_count[3],
			" search %0d, swap %0d, clear %0d, unused %0d.",
			kind_count[4], kind_count[5], kind_count[6], kind_count[7]);
		if (sb.errors == 0 && sb.list_replies.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
